// ===== hdl/svpwm_mmi_pkg.sv =====
// Package: widths, constants, stage payload types and helper functions of the SVPWM modulator.
`timescale 1ns / 1ps
package svpwm_mmi_pkg;

  localparam int VOLT_W    = 16;             // Q8.8 voltage fields
  localparam int COUNT_W   = 16;             // timer compare / period width
  localparam int DUTY_W    = 17;             // Q1.16 duty, 65536 is full
  localparam int PHASE_W   = VOLT_W + 19;    // phase voltage in 2^-25 V units
  localparam int OFS_W     = PHASE_W + 2;    // phase offset in 2^-26 V units
  localparam int DEN_W     = VOLT_W + 2;     // four times the bus voltage
  localparam int QUO_W     = 16;             // quotient bits below the overflow test
  localparam int NLANE     = 3;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [COUNT_W-1:0] PERIOD_RESET = COUNT_W'(1000);
  localparam logic [VOLT_W-1:0]  BUS_MIN      = VOLT_W'(256);
  localparam logic [DUTY_W-1:0]  DUTY_HALF    = DUTY_W'(32768);
  localparam logic [DUTY_W-1:0]  DUTY_FULL    = DUTY_W'(65536);
  // sqrt(3)/2 in Q1.15 (28378), scaled by four to land in 2^-25 V units.
  localparam logic signed [PHASE_W-1:0] SQRT3_X4 = PHASE_W'(113512);

  // Register index decoded from paddr[2].
  typedef enum logic {
    REG_PERIOD = 1'b0,
    REG_NONE   = 1'b1
  } reg_idx_e;

  // Word handed from the transform stages to the divider.
  typedef struct packed {
    logic [NLANE-1:0][OFS_W-1:0] num;
    logic [NLANE-1:0]            neg;
    logic [DEN_W-1:0]            den;
  } div_in_t;

  // Word handed from the divider to the duty stages.
  typedef struct packed {
    logic [NLANE-1:0][QUO_W-1:0] quo;
    logic [NLANE-1:0]            ovf;
    logic [NLANE-1:0]            neg;
  } div_out_t;

  // One restoring division step: returns {remainder, shifted word with new quotient bit}.
  function automatic logic [DEN_W+QUO_W-1:0] div_step(
    input logic [DEN_W-1:0] rem,
    input logic [QUO_W-1:0] w,
    input logic [DEN_W-1:0] den
  );
    logic [DEN_W:0]   t;
    logic [DEN_W-1:0] r;
    logic             qb;
    t  = {rem, w[QUO_W-1]};
    qb = (t >= {1'b0, den});
    r  = qb ? DEN_W'(t - {1'b0, den}) : t[DEN_W-1:0];
    return {r, w[QUO_W-2:0], qb};
  endfunction

  // Half duty plus or minus the quotient, saturated to 0..full.
  function automatic logic [DUTY_W-1:0] sat_duty(
    input logic [QUO_W-1:0] q,
    input logic             ovf,
    input logic             neg
  );
    logic big;
    big = ovf || ({1'b0, q} > DUTY_HALF);
    if (neg) return big ? '0 : DUTY_W'(DUTY_HALF - {1'b0, q});
    else     return big ? DUTY_FULL : DUTY_W'(DUTY_HALF + {1'b0, q});
  endfunction

endpackage

// ===== hdl/svpwm_mmi_if.sv =====
// Valid/ready channel interfaces for the voltage vector and the compare result.
`timescale 1ns / 1ps
interface svpwm_mmi_in_if;
  import svpwm_mmi_pkg::*;
  logic              valid;
  logic              ready;
  logic [VOLT_W-1:0] v_alpha;
  logic [VOLT_W-1:0] v_beta;
  logic [VOLT_W-1:0] bus_voltage;
  modport source (output valid, v_alpha, v_beta, bus_voltage, input ready);
  modport sink   (input valid, v_alpha, v_beta, bus_voltage, output ready);
endinterface

interface svpwm_mmi_out_if;
  import svpwm_mmi_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] compare_a;
  logic [COUNT_W-1:0] compare_b;
  logic [COUNT_W-1:0] compare_c;
  logic [DUTY_W-1:0]  peak_duty;
  modport source (output valid, compare_a, compare_b, compare_c, peak_duty, input ready);
  modport sink   (input valid, compare_a, compare_b, compare_c, peak_duty, output ready);
endinterface

// ===== hdl/svpwm_min_max_injection_unit.sv =====
// Top level of the min/max injection space-vector PWM modulator.
//
// Usage: each word on vec_i carries an alpha/beta voltage command and the
// DC bus voltage, all Q8.8. Each word on res_o carries three timer compare
// values and the peak phase duty (Q1.16). Both channels are valid/ready and
// a word moves at a clock edge where both are high.
// The APB port holds pwm_period at byte address 0; write it only while no
// word is in flight.
// From input to output: three transform stages, a 17-stage divider that
// tests for overflow, then produces one quotient bit per stage for all
// three phases, and two stages for duty saturation and compare scaling.
// Throughput is one word per cycle; every stage has its own valid bit and
// takes a new word whenever it is empty or its successor moves.
// Reset clears all valid bits and sets pwm_period to 1000.
// When the receiver stalls, words pack into the empty stages behind the
// output register; vec_i.ready falls only once every stage is full.
`timescale 1ns / 1ps
module svpwm_min_max_injection_unit import svpwm_mmi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  svpwm_mmi_in_if.sink       vec_i,
  svpwm_mmi_out_if.source    res_o
);

  // Configuration register.
  logic [COUNT_W-1:0] period_q;
  reg_idx_e           reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
    end else if (psel && penable && pwrite && reg_idx == REG_PERIOD) begin
      period_q <= pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PERIOD: prdata = PDATA_W'(period_q);
      default:    prdata = '0;
    endcase
  end

  // Datapath chain.
  logic     cl_valid, cl_ready, dv_valid, dv_ready;
  div_in_t  cl_data;
  div_out_t dv_data;

  svpwm_mmi_clarke u_clarke (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (vec_i.valid),
    .ready_o       (vec_i.ready),
    .v_alpha_i     (vec_i.v_alpha),
    .v_beta_i      (vec_i.v_beta),
    .bus_voltage_i (vec_i.bus_voltage),
    .valid_o       (cl_valid),
    .ready_i       (cl_ready),
    .data_o        (cl_data)
  );

  svpwm_mmi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cl_valid),
    .ready_o (cl_ready),
    .data_i  (cl_data),
    .valid_o (dv_valid),
    .ready_i (dv_ready),
    .data_o  (dv_data)
  );

  svpwm_mmi_out u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .period_i (period_q),
    .valid_i  (dv_valid),
    .ready_o  (dv_ready),
    .data_i   (dv_data),
    .res_o    (res_o)
  );

endmodule

// ===== hdl/svpwm_mmi_clarke.sv =====
// Inverse Clarke transform, min/max offset and dividend preparation over three stages.
`timescale 1ns / 1ps
module svpwm_mmi_clarke import svpwm_mmi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [VOLT_W-1:0] v_alpha_i,
  input  logic [VOLT_W-1:0] v_beta_i,
  input  logic [VOLT_W-1:0] bus_voltage_i,
  output logic              valid_o,
  input  logic              ready_i,
  output div_in_t           data_o
);

  logic [2:0] v_q;
  logic [2:0] rdy;

  // Each stage loads when it is empty or its successor takes its word.
  assign rdy[2]  = !v_q[2] || ready_i;
  assign rdy[1]  = !v_q[1] || rdy[2];
  assign rdy[0]  = !v_q[0] || rdy[1];
  assign ready_o = rdy[0];
  assign valid_o = v_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
    end
  end

  // Stage 1: phase voltages and clamped bus denominator.
  logic signed [PHASE_W-1:0] va_x, vb_x, vbk, vah;
  logic [NLANE-1:0][PHASE_W-1:0] ph_d, ph_q;
  logic [DEN_W-1:0] den_d, den1_q, den2_q;
  logic [VOLT_W-1:0] bus_c;

  always_comb begin
    va_x     = PHASE_W'($signed(v_alpha_i));
    vb_x     = PHASE_W'($signed(v_beta_i));
    vbk      = vb_x * SQRT3_X4;
    vah      = va_x <<< 16;
    ph_d[0]  = va_x <<< 17;
    ph_d[1]  = vbk - vah;
    ph_d[2]  = -vbk - vah;
    bus_c    = (bus_voltage_i < BUS_MIN) ? BUS_MIN : bus_voltage_i;
    den_d    = {bus_c, 2'b00};
  end

  // Stage 2: offset from the midpoint of the largest and smallest phase.
  logic signed [PHASE_W-1:0] pmax, pmin;
  logic [NLANE-1:0][OFS_W-1:0] ofs_d, ofs_q;

  always_comb begin
    pmax = $signed(ph_q[0]);
    pmin = $signed(ph_q[0]);
    for (int i = 1; i < NLANE; i++) begin
      if ($signed(ph_q[i]) > pmax) pmax = $signed(ph_q[i]);
      if ($signed(ph_q[i]) < pmin) pmin = $signed(ph_q[i]);
    end
    for (int i = 0; i < NLANE; i++) begin
      ofs_d[i] = (OFS_W'($signed(ph_q[i])) <<< 1) - OFS_W'(pmax) - OFS_W'(pmin);
    end
  end

  // Stage 3: magnitude, biased up for negative offsets so the divide floors.
  div_in_t dv_d, dv_q;
  logic [OFS_W-1:0] mag;

  always_comb begin
    dv_d.den = den2_q;
    mag      = '0;
    for (int i = 0; i < NLANE; i++) begin
      dv_d.neg[i] = ofs_q[i][OFS_W-1];
      mag         = dv_d.neg[i] ? OFS_W'(-ofs_q[i]) : ofs_q[i];
      dv_d.num[i] = dv_d.neg[i] ? OFS_W'(mag + OFS_W'(den2_q) - OFS_W'(1)) : mag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i) begin
      ph_q   <= ph_d;
      den1_q <= den_d;
    end
    if (rdy[1] && v_q[0]) begin
      ofs_q  <= ofs_d;
      den2_q <= den1_q;
    end
    if (rdy[2] && v_q[1]) begin
      dv_q <= dv_d;
    end
  end

  assign data_o = dv_q;

endmodule

// ===== hdl/svpwm_mmi_div.sv =====
// Pipelined restoring divider, three lanes sharing one denominator, one quotient bit a stage after an overflow test.
`timescale 1ns / 1ps
module svpwm_mmi_div import svpwm_mmi_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  div_in_t  data_i,
  output logic     valid_o,
  input  logic     ready_i,
  output div_out_t data_o
);

  localparam int NST = QUO_W + 1;

  logic [NST-1:0] v_q;
  logic [NST-1:0] rdy;

  logic [DEN_W-1:0]             den_q [NST];
  logic [NLANE-1:0]             ovf_q [NST];
  logic [NLANE-1:0]             neg_q [NST];
  logic [NLANE-1:0][DEN_W-1:0]  rem_q [NST];
  logic [NLANE-1:0][QUO_W-1:0]  w_q   [NST];

  logic [NLANE-1:0][DEN_W-1:0]  rem_d [NST];
  logic [NLANE-1:0][QUO_W-1:0]  w_d   [NST];
  logic [NLANE-1:0]             ovf_d;

  // Ready ripples back from the last stage.
  always_comb begin
    rdy[NST-1] = !v_q[NST-1] || ready_i;
    for (int s = NST - 2; s >= 0; s--) begin
      rdy[s] = !v_q[s] || rdy[s+1];
    end
  end
  assign ready_o = rdy[0];
  assign valid_o = v_q[NST-1];

  // First stage checks for a quotient of 2^16 or more; later stages yield one bit each.
  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      ovf_d[l]    = ({1'b0, data_i.num[l][OFS_W-1:QUO_W]}
                     >= (OFS_W - QUO_W + 1)'(data_i.den));
      rem_d[0][l] = data_i.num[l][QUO_W+DEN_W-1:QUO_W];
      w_d[0][l]   = data_i.num[l][QUO_W-1:0];
    end
    for (int s = 1; s < NST; s++) begin
      for (int l = 0; l < NLANE; l++) begin
        {rem_d[s][l], w_d[s][l]} = div_step(rem_q[s-1][l], w_q[s-1][l], den_q[s-1]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      for (int s = 1; s < NST; s++) begin
        if (rdy[s]) v_q[s] <= v_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i) begin
      den_q[0] <= data_i.den;
      ovf_q[0] <= ovf_d;
      neg_q[0] <= data_i.neg;
      rem_q[0] <= rem_d[0];
      w_q[0]   <= w_d[0];
    end
    for (int s = 1; s < NST; s++) begin
      if (rdy[s] && v_q[s-1]) begin
        den_q[s] <= den_q[s-1];
        ovf_q[s] <= ovf_q[s-1];
        neg_q[s] <= neg_q[s-1];
        rem_q[s] <= rem_d[s];
        w_q[s]   <= w_d[s];
      end
    end
  end

  assign data_o.quo = w_q[NST-1];
  assign data_o.ovf = ovf_q[NST-1];
  assign data_o.neg = neg_q[NST-1];

endmodule

// ===== hdl/svpwm_mmi_out.sv =====
// Duty saturation, peak search and compare scaling, ending in the output register.
`timescale 1ns / 1ps
module svpwm_mmi_out import svpwm_mmi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [COUNT_W-1:0] period_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  div_out_t           data_i,
  svpwm_mmi_out_if.source    res_o
);

  logic [1:0] v_q;
  logic [1:0] rdy;

  assign rdy[1]  = !v_q[1] || res_o.ready;
  assign rdy[0]  = !v_q[0] || rdy[1];
  assign ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
    end
  end

  // Stage 1: clamped duties and the largest of them.
  logic [NLANE-1:0][DUTY_W-1:0] duty_d, duty_q;
  logic [DUTY_W-1:0] pk_d, pk_q;

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      duty_d[l] = sat_duty(data_i.quo[l], data_i.ovf[l], data_i.neg[l]);
    end
    pk_d = duty_d[0];
    for (int l = 1; l < NLANE; l++) begin
      if (duty_d[l] > pk_d) pk_d = duty_d[l];
    end
  end

  // Stage 2: scale each duty by the period and keep the integer part.
  logic [NLANE-1:0][DUTY_W+COUNT_W-1:0] prod;
  logic [NLANE-1:0][COUNT_W-1:0] cmp_q;
  logic [DUTY_W-1:0] pk_out_q;

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      prod[l] = (DUTY_W + COUNT_W)'(duty_q[l]) * (DUTY_W + COUNT_W)'(period_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i) begin
      duty_q <= duty_d;
      pk_q   <= pk_d;
    end
    if (rdy[1] && v_q[0]) begin
      for (int l = 0; l < NLANE; l++) begin
        cmp_q[l] <= prod[l][COUNT_W+DUTY_W-2:DUTY_W-1];
      end
      pk_out_q <= pk_q;
    end
  end

  assign res_o.valid     = v_q[1];
  assign res_o.compare_a = cmp_q[0];
  assign res_o.compare_b = cmp_q[1];
  assign res_o.compare_c = cmp_q[2];
  assign res_o.peak_duty = pk_out_q;

endmodule

// ===== hdl/svpwm_mmi_checker.sv =====
// Port-level assertions for the modulator, bound to its top level.
`timescale 1ns / 1ps
module svpwm_mmi_props import svpwm_mmi_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               pready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COUNT_W-1:0] compare_a,
  input logic [COUNT_W-1:0] compare_b,
  input logic [COUNT_W-1:0] compare_c,
  input logic [DUTY_W-1:0]  peak_duty
);

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(compare_a) && $stable(compare_b)
      && $stable(compare_c) && $stable(peak_duty))
    else $error("result word changed while stalled");

  // The peak duty never exceeds full scale.
  a_peak_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> peak_duty <= DUTY_FULL)
    else $error("peak duty above full scale");

  // A zero peak duty means every phase is at zero duty.
  a_zero_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && peak_duty == '0 |-> compare_a == '0 && compare_b == '0 && compare_c == '0)
    else $error("nonzero compare with zero peak duty");

  // Min/max injection keeps the midpoint at half duty, so the peak is at least half; a zero peak also passes.
  a_peak_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> peak_duty >= DUTY_HALF || peak_duty == '0)
    else $error("peak duty below half");

  // The configuration port never waits.
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind svpwm_min_max_injection_unit svpwm_mmi_props u_props (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .pready    (pready),
  .out_valid (res_o.valid),
  .out_ready (res_o.ready),
  .compare_a (res_o.compare_a),
  .compare_b (res_o.compare_b),
  .compare_c (res_o.compare_c),
  .peak_duty (res_o.peak_duty)
);

// ===== verif/svpwm_mmi_checker.sv =====
// Checker: watches both channels of the modulator, predicts each result word and compares.
`timescale 1ns / 1ps
module svpwm_mmi_checker import svpwm_mmi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               pready,
  svpwm_mmi_in_if            vec,
  svpwm_mmi_out_if           res,
  output int                 fail_count,
  output int                 pending_count
);

  typedef struct {
    logic [COUNT_W-1:0] cmp_a;
    logic [COUNT_W-1:0] cmp_b;
    logic [COUNT_W-1:0] cmp_c;
    logic [DUTY_W-1:0]  peak;
  } pwm_word_t;

  pwm_word_t          expected_words[$];
  logic [COUNT_W-1:0] period_shadow;

  // Floor division for a positive divisor.
  function automatic longint floor_quot(longint n, longint d);
    if (n >= 0) return n / d;
    return -(((-n) + d - 1) / d);
  endfunction

  // Phase duty from its exact offset, saturated to 0..full.
  function automatic longint clamp_duty(longint p, longint sum, longint den);
    longint duty;
    duty = 32768 + floor_quot(2 * p - sum, den);
    if (duty < 0) duty = 0;
    if (duty > 65536) duty = 65536;
    return duty;
  endfunction

  // Predicts the compare values and peak duty of one voltage vector.
  function automatic pwm_word_t modulate(logic signed [VOLT_W-1:0] va_in,
                                          logic signed [VOLT_W-1:0] vb_in,
                                          logic [VOLT_W-1:0] bus_in,
                                          logic [COUNT_W-1:0] period);
    pwm_word_t w;
    longint va, vb, bus, pa, pb, pc, pmax, pmin, den, da, db, dc, pk;
    va = va_in;
    vb = vb_in;
    bus = bus_in;
    if (bus < 256) bus = 256;
    pa = va * 131072;
    pb = -va * 65536 + vb * 113512;
    pc = -va * 65536 - vb * 113512;
    pmax = pa; pmin = pa;
    if (pb > pmax) pmax = pb;
    if (pb < pmin) pmin = pb;
    if (pc > pmax) pmax = pc;
    if (pc < pmin) pmin = pc;
    den = bus * 4;
    da = clamp_duty(pa, pmax + pmin, den);
    db = clamp_duty(pb, pmax + pmin, den);
    dc = clamp_duty(pc, pmax + pmin, den);
    pk = da;
    if (db > pk) pk = db;
    if (dc > pk) pk = dc;
    w.cmp_a = COUNT_W'((da * longint'(period)) >>> 16);
    w.cmp_b = COUNT_W'((db * longint'(period)) >>> 16);
    w.cmp_c = COUNT_W'((dc * longint'(period)) >>> 16);
    w.peak  = DUTY_W'(pk);
    return w;
  endfunction

  // Track the period register, predict on input words, compare on output words.
  always @(posedge clk_i or negedge rst_ni) begin
    pwm_word_t w;
    if (!rst_ni) begin
      period_shadow <= PERIOD_RESET;
      expected_words.delete();
      fail_count <= 0;
      pending_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_PERIOD)
        period_shadow <= pwdata[COUNT_W-1:0];
      if (vec.valid && vec.ready)
        expected_words.push_back(modulate(vec.v_alpha, vec.v_beta, vec.bus_voltage,
                                          period_shadow));
      if (res.valid && res.ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          w = expected_words.pop_front();
          if (res.compare_a !== w.cmp_a || res.compare_b !== w.cmp_b ||
              res.compare_c !== w.cmp_c || res.peak_duty !== w.peak)
            fail_count <= fail_count + 1;
          if (res.compare_a !== w.cmp_a)
            $error("compare_a expected %0d actual %0d", w.cmp_a, res.compare_a);
          if (res.compare_b !== w.cmp_b)
            $error("compare_b expected %0d actual %0d", w.cmp_b, res.compare_b);
          if (res.compare_c !== w.cmp_c)
            $error("compare_c expected %0d actual %0d", w.cmp_c, res.compare_c);
          if (res.peak_duty !== w.peak)
            $error("peak_duty expected %0d actual %0d", w.peak, res.peak_duty);
        end
      end
      pending_count <= expected_words.size();
    end
  end

endmodule

// ===== verif/svpwm_min_max_injection_unit_test.sv =====
// Testbench top: clock, reset, register writes and vector stimulus with random idling.
`timescale 1ns / 1ps
module svpwm_min_max_injection_unit_test;
  import svpwm_mmi_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 fail_count;
  int                 pending_count;
  int                 send_idle_pct;
  int                 stall_pct;

  svpwm_mmi_in_if  vec ();
  svpwm_mmi_out_if res ();

  svpwm_min_max_injection_unit dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .vec_i(vec), .res_o(res)
  );

  svpwm_mmi_checker checker_i (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .vec(vec), .res(res), .fail_count, .pending_count
  );

  // 10 ns clock.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Receiver stalls at random, once per falling edge.
  always @(negedge clk_i) begin
    res.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Writes the period register through a setup phase and then an access phase.
  task automatic write_period(logic [COUNT_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(0);
    pwdata <= PDATA_W'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Writes an unmapped address, which the block must ignore.
  task automatic write_unmapped(logic [PDATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(4);
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Offers one word and holds it until accepted; called at a falling edge.
  // Valid stays high after acceptance so back-to-back words leave no gap.
  task automatic send_vector(logic [VOLT_W-1:0] va, logic [VOLT_W-1:0] vb,
                             logic [VOLT_W-1:0] bus);
    while ($urandom_range(99) < send_idle_pct) begin
      vec.valid <= 1'b0;
      @(negedge clk_i);
    end
    vec.valid <= 1'b1;
    vec.v_alpha <= va;
    vec.v_beta <= vb;
    vec.bus_voltage <= bus;
    @(posedge clk_i);
    while (!vec.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Random vector: mostly small buses so the duty stays in range, some noise.
  task automatic send_random;
    logic [VOLT_W-1:0] bus;
    case ($urandom_range(3))
      0: bus = VOLT_W'($urandom_range(255));
      1: bus = VOLT_W'($urandom);
      default: bus = VOLT_W'($urandom_range(12800, 256));
    endcase
    if ($urandom_range(1))
      send_vector(VOLT_W'($urandom), VOLT_W'($urandom), bus);
    else
      send_vector(VOLT_W'($urandom_range(511)) - VOLT_W'(256),
                  VOLT_W'($urandom_range(511)) - VOLT_W'(256), bus);
  endtask

  // Stops offering words and lets the pipeline empty before touching the register.
  task automatic drain;
    vec.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  // Run limit.
  initial begin
    #5ms;
    $display("svpwm_min_max_injection_unit test failed");
    $finish;
  end

  initial begin
    logic [COUNT_W-1:0] periods[5];
    periods = '{16'd0, 16'd65535, 16'd1, 16'd1000, 16'd50000};
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    vec.valid = 1'b0;
    vec.v_alpha = '0;
    vec.v_beta = '0;
    vec.bus_voltage = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed vectors at the reset period: field extremes, low bus, clamping.
    send_vector(16'h0000, 16'h0000, 16'h0000);
    send_vector(16'h7fff, 16'h0000, 16'h0100);
    send_vector(16'h8000, 16'h0000, 16'h0100);
    send_vector(16'h0000, 16'h7fff, 16'h00ff);
    send_vector(16'h0000, 16'h8000, 16'hffff);
    send_vector(16'h7fff, 16'h7fff, 16'hffff);
    send_vector(16'h8000, 16'h8000, 16'h0001);
    send_vector(16'hffff, 16'h0001, 16'h0100);
    send_vector(16'h0100, 16'h0000, 16'h0200);
    send_vector(16'h0080, 16'h0080, 16'h0100);
    send_vector(16'hff80, 16'h0040, 16'h8000);
    send_vector(16'h5555, 16'haaaa, 16'h5555);
    send_vector(16'haaaa, 16'h5555, 16'haaaa);
    drain();
    write_unmapped(32'hffff_ffff);
    @(negedge clk_i);

    // Random phases over several periods and idling mixes.
    for (int ph = 0; ph < 5; ph++) begin
      write_period(periods[ph]);
      for (int k = 0; k < 4; k++) begin
        case (k)
          0: begin send_idle_pct = 0;  stall_pct = 0;  end
          1: begin send_idle_pct = 71; stall_pct = 0;  end
          2: begin send_idle_pct = 0;  stall_pct = 71; end
          default: begin send_idle_pct = 13; stall_pct = 13; end
        endcase
        for (int n = 0; n < 32; n++) send_random();
      end
      send_idle_pct = 0;
      stall_pct = 0;
      drain();
    end
    // Extremes again at the largest period.
    write_period(16'hffff);
    send_vector(16'h7fff, 16'h8000, 16'h0000);
    send_vector(16'h8000, 16'h7fff, 16'h0000);
    drain();

    if (fail_count == 0 && pending_count == 0)
      $display("svpwm_min_max_injection_unit test passed");
    else
      $display("svpwm_min_max_injection_unit test failed");
    $finish;
  end

endmodule
